/* rtl/assert_macros.svh */
// assertion macros shared by the guide filter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define GD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("guide filter assertion failed");

// next-cycle implication
`define GD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("guide filter assertion failed");

`endif

/* rtl/gd_pkg.sv */
// types and constants of the guide filter
`default_nettype none

package gd_pkg;

	localparam int SAMPLE_W    = 32;
	localparam int COEF_W      = 32;
	localparam int HIST_W      = 48;
	localparam int ACC_W       = 84;
	localparam int MM_W        = 21;
	localparam int CFG_IDX_W   = 3;
	localparam int SCALE_SHIFT = 16;
	localparam int FRAC_SHIFT  = 30;
	localparam int Q_SHIFT     = 16;

	localparam logic [COEF_W-1:0]   COEF_FF0_RST = 32'h4000_0000;
	localparam logic [COEF_W-1:0]   INV_GAIN_RST = 32'hFFFF_FFFF;
	localparam logic [MM_W-1:0]     MIN_MOVE_RST = 21'd13107;

	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam logic [HIST_W-1:0]   HIST_MAX   = {1'b0, {(HIST_W-1){1'b1}}};
	localparam logic [HIST_W-1:0]   HIST_MIN   = {1'b1, {(HIST_W-1){1'b0}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FF0      = 3'd0,
		REG_FF1      = 3'd1,
		REG_FF2      = 3'd2,
		REG_FB1      = 3'd3,
		REG_FB2      = 3'd4,
		REG_INV_GAIN = 3'd5,
		REG_MIN_MOVE = 3'd6
	} reg_idx_t;

	typedef enum logic [2:0] {
		TERM_FF0 = 3'd0,
		TERM_FF1 = 3'd1,
		TERM_FF2 = 3'd2,
		TERM_FB1 = 3'd3,
		TERM_FB2 = 3'd4
	} term_t;

	typedef struct packed {
		logic start;
		logic clear_acc;
		logic signed_mult;
	} mac_ctl_t;

endpackage

`default_nettype wire

/* rtl/gd_mac.sv */
// bit-serial multiply-accumulate unit, one multiplier bit per cycle
`default_nettype none
`include "assert_macros.svh"

module gd_mac (
	input  logic                              clk,
	input  logic                              arst_n,
	input  gd_pkg::mac_ctl_t                  ctl,
	input  logic signed [gd_pkg::HIST_W-1:0]  operand,
	input  logic        [gd_pkg::COEF_W-1:0]  multiplier,
	output logic signed [gd_pkg::ACC_W-1:0]   acc,
	output logic                              done
);
	import gd_pkg::*;

	localparam int CNT_W = $clog2(COEF_W);

	logic signed [ACC_W-1:0] opnd_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] addend;
	logic        [COEF_W-1:0] mult_q;
	logic        [CNT_W-1:0]  cnt_q;
	logic                     busy_q;
	logic                     signed_q;
	logic                     done_q;
	logic                     last;

	assign last = (cnt_q == CNT_W'(COEF_W - 1));

	// top bit of a signed multiplier has negative weight
	always_comb begin
		if (!mult_q[0]) begin
			addend = '0;
		end else if (last && signed_q) begin
			addend = -opnd_q;
		end else begin
			addend = opnd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
			signed_q <= 1'b0;
		end else begin
			done_q <= busy_q && last;
			if (ctl.start) begin
				busy_q   <= 1'b1;
				cnt_q    <= '0;
				signed_q <= ctl.signed_mult;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			opnd_q <= ACC_W'(operand);
			mult_q <= multiplier;
			if (ctl.clear_acc) begin
				acc_q <= '0;
			end
		end else if (busy_q) begin
			acc_q  <= acc_q + addend;
			opnd_q <= opnd_q <<< 1;
			mult_q <= mult_q >> 1;
		end
	end

	assign acc  = acc_q;
	assign done = done_q;

	`GD_ASSERT_IMP(a_start_when_free, clk, arst_n, ctl.start, !busy_q)

endmodule

`default_nettype wire

/* rtl/iir_guide_filter_deadband_top.sv */
// top level of the deadband iir guide filter
//
//  channel | signals                                  | moves
//  --------+------------------------------------------+----------------------------
//  in      | in_valid, in_ready, error_sample         | one error sample per word
//  out     | out_valid, out_ready, correction, satur. | one correction per word
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data| one register write per word
//
// each sample runs 2*FILTER_ORDER+2 multiplies through the bit-serial mac, followed by the
// clipping, difference, rounding and output steps, and returns to idle before the next accept
// the mac handles one multiplier bit per cycle; all products share it
// in_ready is high only between samples; the output register holds a finished word
// so a new sample may start while the last correction is still waiting
// reset and any coefficient write clear both histories and the correction sum
`default_nettype none
`include "assert_macros.svh"

module iir_guide_filter_deadband_top #(
	parameter int FILTER_ORDER = 2
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [gd_pkg::SAMPLE_W-1:0]   error_sample,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [gd_pkg::SAMPLE_W-1:0]   correction,
	output logic                                 saturated,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic        [gd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic        [gd_pkg::COEF_W-1:0]     cfg_data
);
	import gd_pkg::*;

	localparam int D_W   = HIST_W + 1;
	localparam int RND_W = D_W + 1;
	localparam int R_W   = RND_W - Q_SHIFT;
	localparam int SH_W  = ACC_W - FRAC_SHIFT;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_SCALE = 7'b0000010,
		ST_TERMS = 7'b0000100,
		ST_CLIP  = 7'b0001000,
		ST_DIFF  = 7'b0010000,
		ST_ROUND = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t state_q;

	logic signed [COEF_W-1:0]   ff0_q, ff1_q, ff2_q, fb1_q, fb2_q;
	logic        [COEF_W-1:0]   inv_gain_q;
	logic        [MM_W-1:0]     min_move_q;

	logic signed [HIST_W-1:0]   xs_q, xh0_q, xh1_q, yh0_q, yh1_q, y_q;
	logic signed [SAMPLE_W-1:0] csum_q, corr_q;
	logic signed [D_W-1:0]      d_q;
	logic                       sat_q;
	term_t                      term_q;

	logic signed [SAMPLE_W-1:0] correction_q;
	logic                       saturated_q;
	logic                       out_valid_q;

	logic                       in_accept;
	logic                       cfg_accept;
	logic                       coef_write;
	logic                       slot_free;

	logic signed [SAMPLE_W:0]   u_wide;
	logic                       u_clip;
	logic signed [SAMPLE_W-1:0] u_sat;

	mac_ctl_t                   mac_ctl;
	logic signed [HIST_W-1:0]   mac_operand;
	logic        [COEF_W-1:0]   mac_mult;
	logic signed [ACC_W-1:0]    mac_acc;
	logic                       mac_done;

	term_t                      term_nxt;
	term_t                      last_term;
	logic signed [HIST_W-1:0]   xs_now;
	logic signed [HIST_W-1:0]   term_opnd;
	logic signed [COEF_W-1:0]   term_coef;

	logic        [SH_W-1:0]     sh;
	logic        [SH_W-HIST_W:0] y_hi;
	logic                       y_clip;
	logic signed [HIST_W-1:0]   y_sat;

	logic        [D_W-1:0]      mag;
	logic        [D_W-1:0]      thr;
	logic                       dead;
	logic signed [RND_W-1:0]    rnd;
	logic        [R_W-1:0]      r_sh;
	logic                       r_clip;
	logic signed [SAMPLE_W-1:0] r_sat;

	logic signed [SAMPLE_W:0]   s_wide;
	logic                       s_clip;
	logic signed [SAMPLE_W-1:0] s_sat;

	assign in_ready   = (state_q == ST_IDLE);
	assign in_accept  = in_valid && in_ready;
	assign cfg_ready  = 1'b1;
	assign cfg_accept = cfg_valid && cfg_ready;
	assign slot_free  = !out_valid_q || out_ready;

	assign coef_write = cfg_accept && ((cfg_index == REG_FF0) || (cfg_index == REG_FF1) ||
		(cfg_index == REG_FF2) || (cfg_index == REG_FB1) || (cfg_index == REG_FB2));

	// input plus correction sum
	assign u_wide = {error_sample[SAMPLE_W-1], error_sample} + {csum_q[SAMPLE_W-1], csum_q};
	assign u_clip = (u_wide[SAMPLE_W] != u_wide[SAMPLE_W-1]);
	assign u_sat  = u_clip ? (u_wide[SAMPLE_W] ? SAMPLE_MIN : SAMPLE_MAX)
		: u_wide[SAMPLE_W-1:0];

	assign xs_now = $signed(mac_acc[SCALE_SHIFT +: HIST_W]);

	// term sequence
	assign last_term = (FILTER_ORDER > 1) ? TERM_FB2 : TERM_FB1;

	always_comb begin
		case (term_q)
			TERM_FF0: term_nxt = TERM_FF1;
			TERM_FF1: term_nxt = (FILTER_ORDER > 1) ? TERM_FF2 : TERM_FB1;
			TERM_FF2: term_nxt = TERM_FB1;
			TERM_FB1: term_nxt = TERM_FB2;
			default:  term_nxt = TERM_FB2;
		endcase
	end

	always_comb begin
		case (term_nxt)
			TERM_FF1: begin
				term_opnd = xh0_q;
				term_coef = ff1_q;
			end
			TERM_FF2: begin
				term_opnd = xh1_q;
				term_coef = ff2_q;
			end
			TERM_FB1: begin
				term_opnd = yh0_q;
				term_coef = fb1_q;
			end
			TERM_FB2: begin
				term_opnd = yh1_q;
				term_coef = fb2_q;
			end
			default: begin
				term_opnd = xs_q;
				term_coef = ff0_q;
			end
		endcase
	end

	// mac sequencing
	always_comb begin
		mac_ctl     = '0;
		mac_operand = term_opnd;
		mac_mult    = term_coef;
		case (state_q)
			ST_IDLE: begin
				mac_ctl.start     = in_accept;
				mac_ctl.clear_acc = 1'b1;
				mac_operand       = HIST_W'(u_sat);
				mac_mult          = inv_gain_q;
			end
			ST_SCALE: begin
				mac_ctl.start       = mac_done;
				mac_ctl.clear_acc   = 1'b1;
				mac_ctl.signed_mult = 1'b1;
				mac_operand         = xs_now;
				mac_mult            = ff0_q;
			end
			ST_TERMS: begin
				mac_ctl.start       = mac_done && (term_q != last_term);
				mac_ctl.signed_mult = 1'b1;
			end
			default: begin
				mac_ctl = '0;
			end
		endcase
	end

	gd_mac u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (mac_ctl),
		.operand    (mac_operand),
		.multiplier (mac_mult),
		.acc        (mac_acc),
		.done       (mac_done)
	);

	// filter output back to q32.16 with clipping
	assign sh     = mac_acc[ACC_W-1:FRAC_SHIFT];
	assign y_hi   = sh[SH_W-1:HIST_W-1];
	assign y_clip = !((&y_hi) || !(|y_hi));
	assign y_sat  = y_clip ? (sh[SH_W-1] ? HIST_MIN : HIST_MAX) : sh[HIST_W-1:0];

	// deadband and rounding
	assign mag    = d_q[D_W-1] ? D_W'(-d_q) : D_W'(d_q);
	assign thr    = D_W'({min_move_q, {Q_SHIFT{1'b0}}});
	assign dead   = (mag < thr);
	assign rnd    = RND_W'(d_q) + RND_W'(1 << (Q_SHIFT - 1));
	assign r_sh   = rnd[RND_W-1:Q_SHIFT];
	assign r_clip = !((&r_sh[R_W-1:SAMPLE_W-1]) || !(|r_sh[R_W-1:SAMPLE_W-1]));
	assign r_sat  = r_clip ? (r_sh[R_W-1] ? SAMPLE_MIN : SAMPLE_MAX) : r_sh[SAMPLE_W-1:0];

	// accumulator update
	assign s_wide = {csum_q[SAMPLE_W-1], csum_q} + {corr_q[SAMPLE_W-1], corr_q};
	assign s_clip = (s_wide[SAMPLE_W] != s_wide[SAMPLE_W-1]);
	assign s_sat  = s_clip ? (s_wide[SAMPLE_W] ? SAMPLE_MIN : SAMPLE_MAX)
		: s_wide[SAMPLE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			term_q      <= TERM_FF0;
			out_valid_q <= 1'b0;
			sat_q       <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						sat_q   <= u_clip;
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					if (mac_done) begin
						term_q  <= TERM_FF0;
						state_q <= ST_TERMS;
					end
				end
				ST_TERMS: begin
					if (mac_done) begin
						if (term_q == last_term) begin
							state_q <= ST_CLIP;
						end else begin
							term_q <= term_nxt;
						end
					end
				end
				ST_CLIP: begin
					sat_q   <= sat_q || y_clip;
					state_q <= ST_DIFF;
				end
				ST_DIFF: begin
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					sat_q   <= sat_q || (!dead && r_clip);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// registers and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ff0_q      <= COEF_FF0_RST;
			ff1_q      <= '0;
			ff2_q      <= '0;
			fb1_q      <= '0;
			fb2_q      <= '0;
			inv_gain_q <= INV_GAIN_RST;
			min_move_q <= MIN_MOVE_RST;
			xh0_q      <= '0;
			xh1_q      <= '0;
			yh0_q      <= '0;
			yh1_q      <= '0;
			csum_q     <= '0;
		end else begin
			if (cfg_accept) begin
				case (cfg_index)
					REG_FF0:      ff0_q      <= cfg_data;
					REG_FF1:      ff1_q      <= cfg_data;
					REG_FF2:      ff2_q      <= cfg_data;
					REG_FB1:      fb1_q      <= cfg_data;
					REG_FB2:      fb2_q      <= cfg_data;
					REG_INV_GAIN: inv_gain_q <= cfg_data;
					REG_MIN_MOVE: min_move_q <= cfg_data[MM_W-1:0];
					default:      ;
				endcase
			end
			if (coef_write) begin
				xh0_q  <= '0;
				xh1_q  <= '0;
				yh0_q  <= '0;
				yh1_q  <= '0;
				csum_q <= '0;
			end else begin
				if (state_q == ST_DIFF) begin
					xh1_q <= xh0_q;
					xh0_q <= xs_q;
					yh1_q <= yh0_q;
					yh0_q <= y_q;
				end
				if ((state_q == ST_DONE) && slot_free) begin
					csum_q <= s_sat;
				end
			end
		end
	end

	// datapath words
	always_ff @(posedge clk) begin
		if ((state_q == ST_SCALE) && mac_done) begin
			xs_q <= xs_now;
		end
		if (state_q == ST_CLIP) begin
			y_q <= y_sat;
		end
		if (state_q == ST_DIFF) begin
			d_q <= {y_q[HIST_W-1], y_q} -
				D_W'($signed({csum_q, {Q_SHIFT{1'b0}}}));
		end
		if (state_q == ST_ROUND) begin
			corr_q <= dead ? '0 : r_sat;
		end
		if ((state_q == ST_DONE) && slot_free) begin
			correction_q <= corr_q;
			saturated_q  <= sat_q || s_clip;
		end
	end

	assign out_valid  = out_valid_q;
	assign correction = correction_q;
	assign saturated  = saturated_q;

	`GD_ASSERT_NXT(a_accept_leaves_idle, clk, arst_n, in_valid && in_ready, !in_ready)
	`GD_ASSERT_IMP(a_mac_done_in_mult, clk, arst_n, mac_done, (state_q == ST_SCALE) || (state_q == ST_TERMS))
	`GD_ASSERT_NXT(a_result_loaded, clk, arst_n, (state_q == ST_DONE) && slot_free, out_valid && in_ready)

endmodule

`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 100ps
// self-checking testbench for the deadband iir guide filter: directed and random samples
module tb_top;
	import gd_pkg::*;

	localparam int ORDER         = 2;
	localparam int PHASES        = 12;
	localparam int PHASE_WORDS   = 155;
	localparam int HOLD_AT       = 700;
	localparam int HOLD_CYCLES   = 2000;
	localparam int TAIL_CYCLES   = 250;
	localparam int PHASE_LOWPASS = 0;
	localparam int PHASE_WILD    = 1;
	localparam int PHASE_EXTREME = 2;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 3'd7;
	localparam logic [COEF_W-1:0]    Q30_ONE      = 32'h4000_0000;
	localparam logic [COEF_W-1:0]    MIN_MOVE_TOP = 32'd1310720;

	typedef struct {
		logic signed [SAMPLE_W-1:0] corr;
		logic                       sat;
	} corr_word_t;

	class guide_corr_board;
		logic signed [COEF_W-1:0] ff_tap [3];
		logic signed [COEF_W-1:0] fb_tap [3];
		logic [COEF_W-1:0]        inv_gain;
		logic [MM_W-1:0]          min_move;
		longint                   x_hist [2];
		longint                   y_hist [2];
		longint                   corr_sum;
		int                       order;
		int                       errors;
		corr_word_t               expected_corr [$];

		function new(int filter_order);
			order = filter_order;
			errors = 0;
			ff_tap[0] = COEF_FF0_RST;
			ff_tap[1] = '0;
			ff_tap[2] = '0;
			fb_tap[0] = '0;
			fb_tap[1] = '0;
			fb_tap[2] = '0;
			inv_gain = INV_GAIN_RST;
			min_move = MIN_MOVE_RST;
			clear_taps();
		endfunction

		function void clear_taps();
			x_hist[0] = 0;
			x_hist[1] = 0;
			y_hist[0] = 0;
			y_hist[1] = 0;
			corr_sum = 0;
		endfunction

		function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
			case (idx)
				REG_FF0: begin
					ff_tap[0] = data;
					clear_taps();
				end
				REG_FF1: begin
					ff_tap[1] = data;
					clear_taps();
				end
				REG_FF2: begin
					ff_tap[2] = data;
					clear_taps();
				end
				REG_FB1: begin
					fb_tap[1] = data;
					clear_taps();
				end
				REG_FB2: begin
					fb_tap[2] = data;
					clear_taps();
				end
				REG_INV_GAIN: inv_gain = data;
				REG_MIN_MOVE: min_move = data[MM_W-1:0];
				default: ;
			endcase
		endfunction

		function longint clip(longint v, longint lo, longint hi, inout logic sat);
			if (v < lo) begin
				sat = 1'b1;
				return lo;
			end
			if (v > hi) begin
				sat = 1'b1;
				return hi;
			end
			return v;
		endfunction

		function void note_sample(logic signed [SAMPLE_W-1:0] sample);
			longint s32_hi, s32_lo, h48_hi, h48_lo;
			longint u, xs, y, d, mag, thresh, corr;
			longint xv [3];
			longint yv [3];
			logic signed [127:0] acc, wx, wc;
			logic sat;
			corr_word_t w;
			s32_hi = longint'($signed(SAMPLE_MAX));
			s32_lo = longint'($signed(SAMPLE_MIN));
			h48_hi = longint'($signed(HIST_MAX));
			h48_lo = longint'($signed(HIST_MIN));
			sat = 1'b0;

			u = clip(longint'(sample) + corr_sum, s32_lo, s32_hi, sat);
			xs = (u * longint'({32'b0, inv_gain})) >>> SCALE_SHIFT;

			xv[0] = xs;
			xv[1] = x_hist[0];
			xv[2] = x_hist[1];
			yv[0] = 0;
			yv[1] = y_hist[0];
			yv[2] = y_hist[1];
			acc = '0;
			for (int i = 0; i <= order && i < 3; i++) begin
				wx = xv[i];
				wc = ff_tap[i];
				acc = acc + wx * wc;
			end
			for (int i = 1; i <= order && i < 3; i++) begin
				wx = yv[i];
				wc = fb_tap[i];
				acc = acc + wx * wc;
			end
			acc = acc >>> FRAC_SHIFT;
			if (acc > h48_hi) begin
				acc = h48_hi;
				sat = 1'b1;
			end else if (acc < h48_lo) begin
				acc = h48_lo;
				sat = 1'b1;
			end
			y = longint'(acc);

			x_hist[1] = x_hist[0];
			x_hist[0] = xs;
			y_hist[1] = y_hist[0];
			y_hist[0] = y;

			d = y - (corr_sum <<< Q_SHIFT);
			mag = (d < 0) ? -d : d;
			thresh = longint'(min_move) <<< Q_SHIFT;
			if (mag < thresh)
				corr = 0;
			else
				corr = clip((d + (longint'(1) <<< (Q_SHIFT - 1))) >>> Q_SHIFT,
					s32_lo, s32_hi, sat);
			corr_sum = clip(corr_sum + corr, s32_lo, s32_hi, sat);

			w.corr = corr[SAMPLE_W-1:0];
			w.sat = sat;
			expected_corr.insert(expected_corr.size(), w);
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_correction(logic signed [SAMPLE_W-1:0] c, logic s);
			corr_word_t w;
			if (expected_corr.size() == 0) begin
				report($sformatf("correction %0d with nothing pending", c));
				return;
			end
			w = expected_corr.pop_front();
			if (c !== w.corr)
				report($sformatf("correction %0d, predicted %0d", c, w.corr));
			if (s !== w.sat)
				report($sformatf("saturated %b, predicted %b", s, w.sat));
		endtask
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] error_sample = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic signed [SAMPLE_W-1:0] correction;
	logic                       saturated;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index = '0;
	logic [COEF_W-1:0]          cfg_data = '0;

	guide_corr_board board = new(ORDER);

	int words_out = 0;
	int stall_left = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	iir_guide_filter_deadband_top #(.FILTER_ORDER(ORDER)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.error_sample(error_sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.correction(correction),
		.saturated(saturated),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#150ms;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 4);
		if (r < 97)
			return $urandom_range(5, 30);
		return $urandom_range(60, 250);
	endfunction

	function automatic int pick_stall();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 4);
		if (r < 95)
			return $urandom_range(5, 40);
		return $urandom_range(80, 300);
	endfunction

	function automatic logic [COEF_W-1:0] pick_extreme();
		case ($urandom_range(0, 3))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return '0;
			default: return Q30_ONE;
		endcase
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
		if (r < 80)
			return 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
		if (r < 92)
			return $urandom;
		case ($urandom_range(0, 4))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return '0;
			3: return 32'sd1;
			default: return -32'sd1;
		endcase
	endfunction

	// receiver: random stalls, one long hold-off, quiet stretches
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				board.check_correction(correction, saturated);
				words_out++;
			end
			if (!hold_done && words_out >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (words_out % 300 < 60 || $urandom_range(0, 15) != 0) begin
				out_ready <= 1'b1;
			end else begin
				stall_left = pick_stall();
				out_ready <= 1'b0;
			end
		end
	end

	task automatic send_sample(input logic signed [SAMPLE_W-1:0] v);
		in_valid <= 1'b1;
		error_sample <= v;
		do @(posedge clk); while (!in_ready);
		board.note_sample(v);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		board.apply_reg(idx, data);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (board.expected_corr.size() != 0)
			@(posedge clk);
	endtask

	task automatic configure_phase(input int kind);
		logic [COEF_W-1:0] value [8];
		logic [COEF_W-1:0] b;
		case (kind)
			PHASE_LOWPASS: begin
				b = $urandom_range(32'h0080_0000, 32'h0800_0000);
				value[REG_FF0] = b;
				value[REG_FF1] = b << 1;
				value[REG_FF2] = b;
				value[REG_FB1] = Q30_ONE + $urandom_range(0, 32'h2800_0000);
				value[REG_FB2] = -$urandom_range(32'h1000_0000, 32'h2C00_0000);
				if ($urandom_range(0, 3) == 0) begin
					value[REG_FF2] = '0;
					value[REG_FB2] = '0;
				end
				value[REG_INV_GAIN] = $urandom_range(32'h8000_0000, 32'hFFFF_FFFF);
				value[REG_MIN_MOVE] = ($urandom_range(0, 4) == 0) ?
					$urandom_range(0, MIN_MOVE_TOP) : $urandom_range(0, 32768);
			end
			PHASE_WILD: begin
				for (int i = REG_FF0; i <= REG_INV_GAIN; i++)
					value[i] = $urandom;
				value[REG_MIN_MOVE] = $urandom_range(0, MIN_MOVE_TOP);
			end
			default: begin
				for (int i = REG_FF0; i <= REG_FB2; i++)
					value[i] = pick_extreme();
				value[REG_INV_GAIN] = $urandom_range(0, 1) ? INV_GAIN_RST : '0;
				value[REG_MIN_MOVE] = $urandom_range(0, 1) ? MIN_MOVE_TOP : '0;
			end
		endcase
		for (int i = REG_FF0; i <= REG_MIN_MOVE; i++)
			if (kind == PHASE_EXTREME || $urandom_range(0, 3) != 0)
				write_reg(i[CFG_IDX_W-1:0], value[i]);
		if ($urandom_range(0, 5) == 0)
			write_reg(REG_UNUSED, $urandom);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		int gap;
		int kind;
		bit steady;
		logic signed [SAMPLE_W-1:0] level;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: unity path, small deadband, input and sum clipping
		send_sample(32'sd0);
		send_sample(32'sd1);
		send_sample(-32'sd1);
		send_sample(32'sd13000);
		send_sample(-32'sd13000);
		send_sample(32'sh0000_4000);
		send_sample(-32'sh0001_8000);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		send_sample(SAMPLE_MIN);
		settle();

		// unknown index, no deadband, zero gain; history kept
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		write_reg(REG_MIN_MOVE, '0);
		write_reg(REG_INV_GAIN, '0);
		cfg_valid <= 1'b0;
		send_sample(32'sh0005_0000);
		send_sample(-32'sh0003_0000);
		send_sample(SAMPLE_MIN);
		settle();

		// extreme taps, the widest deadband the bench uses
		write_reg(REG_FF0, SAMPLE_MIN);
		write_reg(REG_FF1, SAMPLE_MAX);
		write_reg(REG_FF2, SAMPLE_MAX);
		write_reg(REG_FB1, SAMPLE_MIN);
		write_reg(REG_FB2, SAMPLE_MAX);
		write_reg(REG_INV_GAIN, INV_GAIN_RST);
		write_reg(REG_MIN_MOVE, MIN_MOVE_TOP);
		cfg_valid <= 1'b0;
		send_sample(SAMPLE_MAX);
		send_sample(32'sh0001_0000);
		send_sample(SAMPLE_MIN);
		send_sample(-32'sd1);
		send_sample(32'sd0);
		settle();

		// typical low-pass, step response
		write_reg(REG_FF0, 32'h0400_0000);
		write_reg(REG_FF1, 32'h0800_0000);
		write_reg(REG_FF2, 32'h0400_0000);
		write_reg(REG_FB1, 32'h4A00_0000);
		write_reg(REG_FB2, 32'hE666_6666);
		write_reg(REG_MIN_MOVE, 32'd6554);
		cfg_valid <= 1'b0;
		repeat (4) send_sample(32'sh0002_0000);
		settle();

		for (int p = 0; p < PHASES; p++) begin
			if (p == PHASES - 1)
				kind = PHASE_EXTREME;
			else
				kind = ($urandom_range(0, 99) < 65) ? PHASE_LOWPASS :
					($urandom_range(0, 1) ? PHASE_WILD : PHASE_EXTREME);
			configure_phase(kind);
			steady = ($urandom_range(0, 3) == 0);
			level = '0;
			for (int k = 0; k < PHASE_WORDS; k++) begin
				if ($urandom_range(0, 1)) begin
					level = level + 32'($urandom_range(0, 32'h0002_0000)) - 32'h0001_0000;
					send_sample(level + 32'($urandom_range(0, 32'h4000)) - 32'h2000);
				end else begin
					send_sample(pick_sample());
				end
				gap = steady ? 0 : pick_gap();
				if (gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			settle();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.expected_corr.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
